/* hw/rtl/mcm_pkg.sv */
package mcm_pkg;

    localparam int COST_W       = 34;
    localparam int STATUS_W     = 2;
    localparam int DIM_PORT_W   = 10;
    localparam int MAX_MATRICES_DEF = 16;
    localparam int DIM_BITS_DEF = 10;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIAG,
        S_LDA,
        S_LDB,
        S_LDC,
        S_K,
        S_DRAIN,
        S_WR,
        S_RES,
        S_OUT
    } mcm_state_t;

    typedef struct packed {
        logic dim_we;
        logic ld_a;
        logic ld_c;
        logic issue;
        logic start_int;
        logic cost_we_diag;
        logic cost_we_best;
        logic load_res;
        logic res_zero;
    } mcm_cmd_t;

    typedef struct packed {
        logic busy;
    } mcm_stat_t;

endpackage

/* hw/rtl/mcm_ctrl.sv */
module mcm_ctrl #(
    parameter int MAX_MATRICES = mcm_pkg::MAX_MATRICES_DEF,
    parameter int XW = $clog2(MAX_MATRICES + 1),
    parameter int DA = $clog2(MAX_MATRICES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [mcm_pkg::STATUS_W-1:0] status,
    output mcm_pkg::mcm_cmd_t        cmd,
    input  mcm_pkg::mcm_stat_t       stat,
    output logic [DA-1:0]            dim_waddr,
    output logic [DA-1:0]            dim_raddr,
    output logic [XW-1:0]            i_idx,
    output logic [XW-1:0]            j_idx,
    output logic [XW-1:0]            k_idx
);
    import mcm_pkg::*;

    localparam int NDIMS = MAX_MATRICES + 1;
    localparam int CNT_W = $clog2(NDIMS + 1);

    mcm_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic [XW-1:0] nmat_reg, nmat_next;
    logic [XW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, len_reg, len_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic zero_reg, zero_next;

    logic accept, room, fin_last;
    logic [CNT_W-1:0] cnt_new;
    logic ovf_new;

    // plain dimensions may keep arriving while a result waits; a chain end waits
    assign in_stall = !((state_reg == S_IDLE) || (state_reg == S_OUT && !last));

    assign accept   = in_valid && !in_stall;
    assign room     = cnt_reg < CNT_W'(NDIMS);
    assign cnt_new  = room ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign ovf_new  = ovf_reg || !room;
    assign fin_last = accept && last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (fin_last)
                begin
                    if (ovf_new || cnt_new < CNT_W'(3))
                        state_next = S_RES;
                    else
                        state_next = S_DIAG;
                end
            end
            S_DIAG:
            begin
                if (i_reg == nmat_reg)
                    state_next = S_LDA;
            end
            S_LDA:   state_next = S_LDB;
            S_LDB:   state_next = S_LDC;
            S_LDC:   state_next = S_K;
            S_K:
            begin
                if (k_reg == j_reg - XW'(1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.busy)
                    state_next = S_WR;
            end
            S_WR:
            begin
                if (j_reg == nmat_reg && len_reg == nmat_reg)
                    state_next = S_RES;
                else
                    state_next = S_LDA;
            end
            S_RES:   state_next = S_OUT;
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // counters and loop indices
    always_comb
    begin
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        nmat_next = nmat_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        len_next  = len_reg;
        st_next   = st_reg;
        zero_next = zero_reg;
        if (accept)
        begin
            cnt_next = cnt_new;
            ovf_next = ovf_new;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (fin_last)
                begin
                    cnt_next  = '0;
                    ovf_next  = 1'b0;
                    nmat_next = XW'(cnt_new - CNT_W'(1));
                    i_next    = XW'(1);
                    if (ovf_new)
                    begin
                        st_next   = ST_OVER;
                        zero_next = 1'b1;
                    end
                    else if (cnt_new < CNT_W'(2))
                    begin
                        st_next   = ST_SHORT;
                        zero_next = 1'b1;
                    end
                    else
                    begin
                        st_next   = ST_OK;
                        // a single matrix costs nothing
                        zero_next = (cnt_new == CNT_W'(2));
                    end
                end
            end
            S_DIAG:
            begin
                if (i_reg == nmat_reg)
                begin
                    len_next = XW'(2);
                    i_next   = XW'(1);
                    j_next   = XW'(2);
                end
                else
                    i_next = i_reg + XW'(1);
            end
            S_LDC:   k_next = i_reg;
            S_K:     k_next = k_reg + XW'(1);
            S_WR:
            begin
                if (j_reg == nmat_reg)
                begin
                    len_next = len_reg + XW'(1);
                    i_next   = XW'(1);
                    j_next   = len_reg + XW'(1);
                end
                else
                begin
                    i_next = i_reg + XW'(1);
                    j_next = j_reg + XW'(1);
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        dim_raddr = DA'(k_reg);
        out_valid = 1'b0;
        case (state_reg)
            S_DIAG:  cmd.cost_we_diag = 1'b1;
            S_LDA:   dim_raddr = DA'(i_reg - XW'(1));
            S_LDB:
            begin
                dim_raddr  = DA'(j_reg);
                cmd.ld_a   = 1'b1;
            end
            S_LDC:
            begin
                cmd.ld_c      = 1'b1;
                cmd.start_int = 1'b1;
            end
            S_K:     cmd.issue = 1'b1;
            S_WR:    cmd.cost_we_best = 1'b1;
            S_RES:
            begin
                cmd.load_res = 1'b1;
                cmd.res_zero = zero_reg;
            end
            S_OUT:   out_valid = 1'b1;
            default: ;
        endcase
        cmd.dim_we = accept && room;
    end

    assign dim_waddr = DA'(cnt_reg);
    assign status    = st_reg;
    assign i_idx     = i_reg;
    assign j_idx     = j_reg;
    assign k_idx     = k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            nmat_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            len_reg   <= '0;
            st_reg    <= ST_OK;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            nmat_reg  <= nmat_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            len_reg   <= len_next;
            st_reg    <= st_next;
            zero_reg  <= zero_next;
        end
    end

endmodule

/* hw/rtl/mcm_dpath.sv */
module mcm_dpath #(
    parameter int MAX_MATRICES = mcm_pkg::MAX_MATRICES_DEF,
    parameter int DIM_BITS = mcm_pkg::DIM_BITS_DEF,
    parameter int XW = $clog2(MAX_MATRICES + 1),
    parameter int DA = $clog2(MAX_MATRICES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mcm_pkg::DIM_PORT_W-1:0] dimension,
    input  mcm_pkg::mcm_cmd_t             cmd,
    output mcm_pkg::mcm_stat_t            stat,
    input  logic [DA-1:0]                 dim_waddr,
    input  logic [DA-1:0]                 dim_raddr,
    input  logic [XW-1:0]                 i_idx,
    input  logic [XW-1:0]                 j_idx,
    input  logic [XW-1:0]                 k_idx,
    output logic [mcm_pkg::COST_W-1:0]    min_cost
);
    import mcm_pkg::*;

    localparam int NDIMS = MAX_MATRICES + 1;
    localparam int CDEPTH = MAX_MATRICES * MAX_MATRICES;
    localparam int CA = $clog2(CDEPTH);
    localparam int P1W = 2 * DIM_BITS;
    localparam int P2W = 3 * DIM_BITS;
    localparam int EW = (P2W > COST_W) ? P2W : COST_W;

    function automatic logic [CA-1:0] cost_idx(input logic [XW-1:0] r, input logic [XW-1:0] c);
        cost_idx = CA'((CA'(r) - CA'(1)) * CA'(MAX_MATRICES) + (CA'(c) - CA'(1)));
    endfunction

    logic [DIM_BITS-1:0] dims_mem [NDIMS];
    logic [COST_W-1:0]   cost_mem [CDEPTH];

    logic [DIM_BITS-1:0] dim_rd_reg;
    logic [COST_W-1:0]   cl_reg, cr_reg;
    logic [DIM_BITS-1:0] a_reg, c_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic [P1W-1:0]      prod1_reg;
    logic [COST_W-1:0]   sum_reg, sum2_reg, tri_reg;
    logic [COST_W-1:0]   best_reg, res_reg;
    logic first_reg, first_next;
    logic [COST_W-1:0]   best_next;

    logic [CA-1:0]       cost_waddr;
    logic [COST_W-1:0]   cost_wdata;
    logic [COST_W:0]     s1, s3;
    logic [COST_W-1:0]   sum_next, q;
    logic [P1W-1:0]      prod1_next;
    logic [P2W-1:0]      prod2;
    logic [EW-1:0]       p_ext;
    logic [COST_W-1:0]   tri_next;

    assign cost_waddr = cmd.cost_we_diag ? cost_idx(i_idx, i_idx) : cost_idx(i_idx, j_idx);
    assign cost_wdata = cmd.cost_we_diag ? '0 : best_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.dim_we)
            dims_mem[dim_waddr] <= DIM_BITS'(dimension);
        dim_rd_reg <= dims_mem[dim_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cost_we_diag || cmd.cost_we_best)
            cost_mem[cost_waddr] <= cost_wdata;
        cl_reg <= cost_mem[cost_idx(i_idx, k_idx)];
        cr_reg <= cost_mem[cost_idx(k_idx + XW'(1), j_idx)];
    end

    // stage 1: left + right, first product
    assign s1         = {1'b0, cl_reg} + {1'b0, cr_reg};
    assign sum_next   = s1[COST_W] ? COST_MAX : s1[COST_W-1:0];
    assign prod1_next = P1W'(a_reg) * P1W'(dim_rd_reg);

    // stage 2: second product, saturated
    assign prod2    = P2W'(prod1_reg) * P2W'(c_reg);
    assign p_ext    = EW'(prod2);
    assign tri_next = (p_ext > EW'(COST_MAX)) ? COST_MAX : p_ext[COST_W-1:0];

    // stage 3: total and running minimum, lowest split wins ties
    assign s3 = {1'b0, sum2_reg} + {1'b0, tri_reg};
    assign q  = s3[COST_W] ? COST_MAX : s3[COST_W-1:0];

    always_comb
    begin
        best_next  = best_reg;
        first_next = first_reg;
        if (cmd.start_int)
            first_next = 1'b1;
        else if (v3_reg)
        begin
            first_next = 1'b0;
            if (first_reg || q < best_reg)
                best_next = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_a)
            a_reg <= dim_rd_reg;
        if (cmd.ld_c)
            c_reg <= dim_rd_reg;
        prod1_reg <= prod1_next;
        sum_reg   <= sum_next;
        tri_reg   <= tri_next;
        sum2_reg  <= sum_reg;
        best_reg  <= best_next;
        if (cmd.load_res)
            res_reg <= cmd.res_zero ? '0 : best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= cmd.issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            first_reg <= first_next;
        end
    end

    assign stat.busy = v1_reg || v2_reg || v3_reg;
    assign min_cost  = res_reg;

endmodule

/* hw/rtl/matrix_chain_min_cost.sv */
// Each interval loads its dimensions, issues its split points, drains the pipe and
// writes its best cost; error and single-matrix chains skip straight to the result.
// The split-point loop issues one candidate per cycle into a 3-stage add/multiply pipe.
// Dimension items are taken one per cycle while idle; while a result waits, only items not marked last are taken.
// rst_n is asynchronous: clears the controller and pipe valids; memories are not cleared.
module matrix_chain_min_cost #(
    parameter int MAX_MATRICES = mcm_pkg::MAX_MATRICES_DEF,
    parameter int DIM_BITS = mcm_pkg::DIM_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mcm_pkg::DIM_PORT_W-1:0] dimension,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mcm_pkg::COST_W-1:0]     min_cost,
    output logic [mcm_pkg::STATUS_W-1:0]   status
);
    import mcm_pkg::*;

    localparam int XW = $clog2(MAX_MATRICES + 1);
    localparam int DA = $clog2(MAX_MATRICES + 1);

    mcm_cmd_t  cmd;
    mcm_stat_t stat;
    logic [DA-1:0] dim_waddr, dim_raddr;
    logic [XW-1:0] i_idx, j_idx, k_idx;

    mcm_ctrl #(
        .MAX_MATRICES(MAX_MATRICES),
        .XW(XW),
        .DA(DA)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .last(last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .cmd(cmd),
        .stat(stat),
        .dim_waddr(dim_waddr),
        .dim_raddr(dim_raddr),
        .i_idx(i_idx),
        .j_idx(j_idx),
        .k_idx(k_idx)
    );

    mcm_dpath #(
        .MAX_MATRICES(MAX_MATRICES),
        .DIM_BITS(DIM_BITS),
        .XW(XW),
        .DA(DA)
    ) u_dpath (
        .clk(clk),
        .rst_n(rst_n),
        .dimension(dimension),
        .cmd(cmd),
        .stat(stat),
        .dim_waddr(dim_waddr),
        .dim_raddr(dim_raddr),
        .i_idx(i_idx),
        .j_idx(j_idx),
        .k_idx(k_idx),
        .min_cost(min_cost)
    );

endmodule

/* hw/rtl/mcm_checker.sv */
module mcm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           last,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [mcm_pkg::COST_W-1:0]     min_cost,
    input logic [mcm_pkg::STATUS_W-1:0]   status
);
    import mcm_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_SHORT || status == ST_OVER))
        else $error("bad status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> min_cost == '0)
        else $error("nonzero cost with error status");

    a_end_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> !out_valid)
        else $error("result shown right after chain end");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(min_cost) && $stable(status))
        else $error("stalled result changed");

endmodule

bind matrix_chain_min_cost mcm_checker u_mcm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .min_cost(min_cost),
    .status(status)
);

/* verif/matrix_chain_min_cost_tb.sv */
module matrix_chain_min_cost_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcm_pkg::*;

    localparam int NMAT = MAX_MATRICES_DEF;
    localparam int NDIM = NMAT + 1;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [COST_W-1:0]   cost;
        logic [STATUS_W-1:0] st;
    } chain_result_t;

    typedef struct {
        logic [DIM_PORT_W-1:0] dim;
        logic                  lst;
        logic                  chk;
        logic [COST_W-1:0]     cost;
        logic [STATUS_W-1:0]   st;
    } dim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [DIM_PORT_W-1:0] dimension = '0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COST_W-1:0]     min_cost;
    logic [STATUS_W-1:0]   status;

    matrix_chain_min_cost i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .dimension(dimension), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .min_cost(min_cost), .status(status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [DIM_BITS_DEF-1:0] chain_dims[NDIM];
    int                      chain_len;
    bit                      chain_over;
    chain_result_t           pending_costs[$];
    int                      errors;
    int                      idle_cycles;
    bit                      hold_out;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [COST_W-1:0] sat(input logic [63:0] v);
        return (v > 64'(COST_MAX)) ? COST_MAX : v[COST_W-1:0];
    endfunction

    function automatic logic [COST_W-1:0] chain_min_cost(input int n);
        logic [COST_W-1:0] tbl[NMAT][NMAT];
        logic [COST_W-1:0] best, q;
        int j;
        for (int i = 0; i < n; i++)
            tbl[i][i] = '0;
        for (int len = 2; len <= n; len++)
            for (int i = 0; i + len <= n; i++)
            begin
                j = i + len - 1;
                best = COST_MAX;
                for (int k = i; k < j; k++)
                begin
                    q = sat(64'(tbl[i][k]) + 64'(tbl[k+1][j]));
                    q = sat(64'(q) + 64'(sat(64'(chain_dims[i]) * 64'(chain_dims[k+1])
                                             * 64'(chain_dims[j+1]))));
                    if (k == i || q < best)
                        best = q;
                end
                tbl[i][j] = best;
            end
        return tbl[0][n-1];
    endfunction

    function automatic bit predict_chain(input logic [DIM_PORT_W-1:0] d, input logic l,
                                         output chain_result_t r);
        if (chain_len < NDIM)
        begin
            chain_dims[chain_len] = d[DIM_BITS_DEF-1:0];
            chain_len++;
        end
        else
            chain_over = 1'b1;
        if (!l)
            return 1'b0;
        r.cost = '0;
        if (chain_over)
            r.st = ST_OVER;
        else if (chain_len < 2)
            r.st = ST_SHORT;
        else
        begin
            r.st = ST_OK;
            r.cost = chain_min_cost(chain_len - 1);
        end
        chain_len = 0;
        chain_over = 1'b0;
        return 1'b1;
    endfunction

    // called at a falling edge; leaves the accepted item on the bus until the next call
    task automatic send_dim(input logic [DIM_PORT_W-1:0] d, input logic l, input int gap);
        chain_result_t r;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        dimension <= d;
        last      <= l;
        do @(posedge clk); while (in_stall);
        if (predict_chain(d, l, r))
            pending_costs.push_back(r);
        @(negedge clk);
    endtask

    task automatic send_chain(input int nd, input int maxd);
        for (int i = 0; i < nd; i++)
            send_dim(10'($urandom_range(maxd, 0)), i == nd - 1,
                     $urandom_range(5, 0) * $urandom_range(1, 0));
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        chain_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_costs.size() == 0)
                report_mismatch("unexpected result", 64'(min_cost), 64'(0));
            else
            begin
                want = pending_costs.pop_front();
                if (status !== want.st)
                    report_mismatch("status", 64'(status), 64'(want.st));
                if (min_cost !== want.cost)
                    report_mismatch("min_cost", 64'(min_cost), 64'(want.cost));
            end
        end
    end

    initial
    begin
        int w;
        @(negedge clk);
        forever
        begin
            if (hold_out)
            begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                hold_out = 1'b0;
            end
            w = $urandom_range(5, 0) * $urandom_range(1, 0);
            out_stall <= (w != 0);
            repeat (w) @(negedge clk);
            if (w != 0)
                out_stall <= 1'b0;
            @(negedge clk);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    dim_row_t rows[15] = '{
        '{10'd5,    1'b1, 1'b1, '0, ST_SHORT},   // lone dimension
        '{10'd1023, 1'b0, 1'b0, '0, ST_OK},
        '{10'd1023, 1'b1, 1'b1, '0, ST_OK},      // one matrix costs nothing
        '{10'd1023, 1'b0, 1'b0, '0, ST_OK},
        '{10'd1023, 1'b0, 1'b0, '0, ST_OK},
        '{10'd1023, 1'b1, 1'b1, 34'd1070599167, ST_OK},
        '{10'd0,    1'b0, 1'b0, '0, ST_OK},
        '{10'd0,    1'b1, 1'b1, '0, ST_OK},
        '{10'd10,   1'b0, 1'b0, '0, ST_OK},
        '{10'd30,   1'b0, 1'b0, '0, ST_OK},
        '{10'd5,    1'b0, 1'b0, '0, ST_OK},
        '{10'd60,   1'b1, 1'b1, 34'd4500, ST_OK},
        '{10'd682,  1'b0, 1'b0, '0, ST_OK},
        '{10'd341,  1'b0, 1'b0, '0, ST_OK},
        '{10'd1,    1'b1, 1'b0, '0, ST_OK}
    };

    initial
    begin
        int sent;
        bit paused;
        chain_result_t r;
        errors = 0;
        hold_out = 1'b0;
        chain_len = 0;
        chain_over = 1'b0;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].chk)
            begin
                send_dim(rows[i].dim, rows[i].lst, 0);
                r = pending_costs[$];
                if (r.st !== rows[i].st)
                    report_mismatch("table status", 64'(r.st), 64'(rows[i].st));
                if (r.cost !== rows[i].cost)
                    report_mismatch("table cost", 64'(r.cost), 64'(rows[i].cost));
            end
            else
                send_dim(rows[i].dim, rows[i].lst, $urandom_range(2, 0));
        end
        // full length of max dims, then overflow (18 and 20 dims)
        for (int i = 0; i < NDIM; i++)
            send_dim(10'd1023, i == NDIM - 1, 0);
        for (int i = 0; i < NDIM + 1; i++)
            send_dim(10'($urandom), i == NDIM, 0);
        for (int i = 0; i < NDIM + 3; i++)
            send_dim(10'($urandom), i == NDIM + 2, 0);

        // wait for drain, then receiver holds off while chains keep coming
        in_valid <= 1'b0;
        wait (pending_costs.size() == 0);
        hold_out = 1'b1;
        @(negedge clk);
        sent = 0;
        while (sent < 880)
        begin
            int nd;
            int pick;
            pick = $urandom_range(19, 0);
            if (pick == 0)
                nd = 1;
            else if (pick == 1)
                nd = NDIM + $urandom_range(3, 1);
            else if (pick < 4)
                nd = $urandom_range(NDIM, 12);
            else
                nd = $urandom_range(7, 2);
            send_chain(nd, ($urandom_range(1, 0) != 0) ? 1023 : 15);
            sent += nd;
            if (!paused && sent > 500)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                wait (pending_costs.size() == 0);
                @(negedge clk);
            end
        end
        in_valid <= 1'b0;
        wait (pending_costs.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
